### hw/rtl/hsp_pkg.sv
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared constants, codes, command/status types and helpers for the
// Hermite spline point evaluator.
// ----------------------------------------------------------------------------
package hsp_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int NEWTON_STEPS = 5;
  localparam int MAX_SEGMENTS = 256;

  localparam int SEG_W       = $clog2(MAX_SEGMENTS + 1);
  localparam int COEFF_DEPTH = MAX_SEGMENTS * 8;
  localparam int COEFF_AW    = $clog2(COEFF_DEPTH);
  localparam int KNOT_DEPTH  = MAX_SEGMENTS + 1;
  localparam int KNOT_AW     = $clog2(KNOT_DEPTH);

  // divider: 33-bit magnitude numerator shifted up by FRAC_BITS
  localparam int DIV_STEPS = 33 + FRAC_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam int ITER_W = $clog2(NEWTON_STEPS + 1);

  localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;

  typedef enum logic [1:0] {
    ACT_COEFF = 2'd0,
    ACT_KNOT  = 2'd1,
    ACT_EVAL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_ZDIV  = 2'd2
  } status_e;

  localparam logic REG_NSEG = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_START,
    OP_OOR,
    OP_KCMP,
    OP_K0LD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_TSET,
    OP_DIV_TADD,
    OP_WLOAD,
    OP_MUL_TT,
    OP_WB_T2,
    OP_MUL_T2T,
    OP_WB_T3,
    OP_MULB,
    OP_ACC,
    OP_WB_RESID,
    OP_WB_SLOPE,
    OP_WB_X,
    OP_WB_Y
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_OOR,
    S_KRD,
    S_KCMP,
    S_K0RD,
    S_K0LD,
    S_DIVI,
    S_DIV,
    S_WLD,
    S_BL,
    S_POST,
    S_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    PH_INIT,
    PH_NVAL,
    PH_NSLOPE,
    PH_X,
    PH_Y
  } phase_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] idx;
    logic [1:0] cidx;
    logic       crd;
    logic       cdim;
    logic       krd;
    logic       khi;
    logic       dsel;
    logic       slope;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic plain_oor;
    logic kgt;
    logic seg_last;
    logic div_done;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/hsp_ram.sv
// ----------------------------------------------------------------------------
// hsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hw/rtl/hsp_ctrl.sv
// ----------------------------------------------------------------------------
// hsp_ctrl
// Sequencer: knot search, divider runs, Newton loop and blend steps.
// ----------------------------------------------------------------------------
module hsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  hsp_pkg::action_e  action_i,
  input  logic              knot_mode_i,
  input  logic              nseg_zero_i,
  input  logic              out_free_i,
  input  hsp_pkg::dp_stat_t stat_i,
  output logic              in_stall_o,
  output hsp_pkg::dp_cmd_t  cmd_o
);
  import hsp_pkg::*;

  ctrl_state_e       state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [3:0]        step_q, step_d;
  logic [ITER_W-1:0] iter_q, iter_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_INIT;
      step_q  <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      step_q  <= step_d;
      iter_q  <= iter_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    step_d  = step_q;
    iter_d  = iter_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && action_i == ACT_EVAL) state_d = S_START;
      end
      S_START: begin
        if (nseg_zero_i || (!knot_mode_i && stat_i.plain_oor)) begin
          state_d = S_OOR;
        end else if (knot_mode_i) begin
          phase_d = PH_INIT;
          state_d = S_KRD;
        end else begin
          phase_d = PH_X;
          step_d  = '0;
          state_d = S_WLD;
        end
      end
      S_OOR:  state_d = S_DONE;
      S_KRD:  state_d = S_KCMP;
      S_KCMP: begin
        if (stat_i.kgt && !stat_i.seg_last) state_d = S_KRD;
        else if (stat_i.kgt)                state_d = S_OOR;
        else                                state_d = S_K0RD;
      end
      S_K0RD: state_d = S_K0LD;
      S_K0LD: state_d = S_DIVI;
      S_DIVI: state_d = S_DIV;
      S_DIV: begin
        if (stat_i.div_done) begin
          step_d = '0;
          if (phase_q == PH_INIT) begin
            phase_d = PH_NVAL;
            iter_d  = '0;
            state_d = S_WLD;
          end else if (iter_q == ITER_W'(NEWTON_STEPS - 1)) begin
            phase_d = PH_X;
            state_d = S_WLD;
          end else begin
            iter_d  = iter_q + 1'b1;
            phase_d = PH_NVAL;
            state_d = S_BL;
          end
        end
      end
      S_WLD: begin
        if (step_q == 4'd4) begin
          step_d  = '0;
          state_d = S_BL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_BL: begin
        if (step_q == 4'd11) state_d = S_POST;
        else                 step_d  = step_q + 1'b1;
      end
      S_POST: begin
        step_d = '0;
        unique case (phase_q)
          PH_NVAL: begin
            phase_d = PH_NSLOPE;
            state_d = S_BL;
          end
          PH_NSLOPE: state_d = S_DIVI;
          PH_X: begin
            phase_d = PH_Y;
            state_d = S_WLD;
          end
          PH_Y:    state_d = S_DONE;
          default: state_d = S_IDLE;
        endcase
      end
      S_DONE: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = OP_NOP;
    cmd_o.slope = (phase_q == PH_NSLOPE);
    cmd_o.dsel  = (phase_q == PH_NSLOPE);
    cmd_o.cdim  = (phase_q != PH_X);
    in_stall_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && action_i == ACT_EVAL) cmd_o.op = OP_CAPTURE;
      end
      S_START: cmd_o.op = OP_START;
      S_OOR:   cmd_o.op = OP_OOR;
      S_KRD: begin
        cmd_o.krd = 1'b1;
        cmd_o.khi = 1'b1;
      end
      S_KCMP: cmd_o.op  = OP_KCMP;
      S_K0RD: cmd_o.krd = 1'b1;
      S_K0LD: cmd_o.op  = OP_K0LD;
      S_DIVI: cmd_o.op  = OP_DIV_INIT;
      S_DIV: begin
        if (!stat_i.div_done)        cmd_o.op = OP_DIV_STEP;
        else if (phase_q == PH_INIT) cmd_o.op = OP_DIV_TSET;
        else                         cmd_o.op = OP_DIV_TADD;
      end
      S_WLD: begin
        cmd_o.crd  = (step_q != 4'd4);
        cmd_o.cidx = step_q[1:0];
        if (step_q != 4'd0) begin
          cmd_o.op  = OP_WLOAD;
          cmd_o.idx = 2'(step_q - 4'd1);
        end
      end
      S_BL: begin
        cmd_o.idx = 2'((step_q - 4'd4) >> 1);
        case (step_q)
          4'd0:    cmd_o.op = OP_MUL_TT;
          4'd1:    cmd_o.op = OP_WB_T2;
          4'd2:    cmd_o.op = OP_MUL_T2T;
          4'd3:    cmd_o.op = OP_WB_T3;
          default: cmd_o.op = step_q[0] ? OP_ACC : OP_MULB;
        endcase
      end
      S_POST: begin
        unique case (phase_q)
          PH_NVAL:   cmd_o.op = OP_WB_RESID;
          PH_NSLOPE: cmd_o.op = OP_WB_SLOPE;
          PH_X:      cmd_o.op = OP_WB_X;
          PH_Y:      cmd_o.op = OP_WB_Y;
          default:   cmd_o.op = OP_NOP;
        endcase
      end
      S_DONE: cmd_o.out_load = out_free_i;
      default: cmd_o.op = OP_NOP;
    endcase
  end

endmodule

### hw/rtl/hsp_dp.sv
// ----------------------------------------------------------------------------
// hsp_dp
// Datapath: shared 32x32 multiplier, basis terms, accumulator, radix-2
// divider and the segment/parameter registers.
// ----------------------------------------------------------------------------
module hsp_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hsp_pkg::dp_cmd_t               cmd_i,
  input  logic signed [31:0]             query_param_i,
  input  logic [hsp_pkg::SEG_W-1:0]      nseg_i,
  input  logic signed [31:0]             kdata_i,
  input  logic signed [31:0]             cdata_i,
  output logic [hsp_pkg::KNOT_AW-1:0]    kaddr_o,
  output logic [hsp_pkg::COEFF_AW-1:0]   caddr_o,
  output hsp_pkg::dp_stat_t              stat_o,
  output logic signed [31:0]             point_x_o,
  output logic signed [31:0]             point_y_o,
  output hsp_pkg::status_e               status_o
);
  import hsp_pkg::*;

  logic signed [31:0] q_q, t_q, t2_q, t3_q, k0_q, k1_q, resid_q, slope_q;
  logic signed [31:0] x_q, y_q;
  logic signed [31:0] w_q [4];
  logic signed [63:0] prod_q, acc_q;
  logic [SEG_W-1:0]   seg_q;

  logic [32:0]          rem_q, dmag_q;
  logic [DIV_STEPS-1:0] dq_q;
  logic [DCNT_W-1:0]    dcnt_q;
  logic                 nsgn_q, nzero_q, qneg_q, dnz_q;
  logic                 zero_q, oor_q;

  // basis term for the current weight
  logic signed [63:0] te, t2e, t3e, basis;
  assign te  = 64'(t_q);
  assign t2e = 64'(t2_q);
  assign t3e = 64'(t3_q);

  always_comb begin
    case ({cmd_i.slope, cmd_i.idx})
      3'b000:  basis = 64'sd2 * t3e - 64'sd3 * t2e + ONE_FX;
      3'b001:  basis = 64'sd3 * t2e - 64'sd2 * t3e;
      3'b010:  basis = t3e - 64'sd2 * t2e + te;
      3'b011:  basis = t3e - t2e;
      3'b100:  basis = 64'sd6 * t2e - 64'sd6 * te;
      3'b101:  basis = 64'sd6 * te - 64'sd6 * t2e;
      3'b110:  basis = 64'sd3 * t2e - 64'sd4 * te + ONE_FX;
      default: basis = 64'sd3 * t2e - 64'sd2 * te;
    endcase
  end

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p, prod_sh;
  always_comb begin
    case (cmd_i.op)
      OP_MUL_TT: begin
        mul_a = t_q;
        mul_b = t_q;
      end
      OP_MUL_T2T: begin
        mul_a = t2_q;
        mul_b = t_q;
      end
      default: begin
        mul_a = w_q[cmd_i.idx];
        mul_b = sat32(basis);
      end
    endcase
  end
  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign prod_sh = prod_q >>> FRAC_BITS;

  // divider operands and result
  logic signed [63:0] num, den;
  logic [32:0]        nmag, dmag;
  assign num  = cmd_i.dsel ? 64'(resid_q) : 64'(q_q) - 64'(k0_q);
  assign den  = cmd_i.dsel ? 64'(slope_q) : 64'(k1_q) - 64'(k0_q);
  assign nmag = num[63] ? 33'(-num) : num[32:0];
  assign dmag = den[63] ? 33'(-den) : den[32:0];

  logic [33:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_q, dq_q[DIV_STEPS-1]};
  assign rem_ge = rem_sh >= {1'b0, dmag_q};

  logic signed [31:0] dres;
  always_comb begin
    if (!dnz_q) begin
      dres = nzero_q ? 32'sd0 : (nsgn_q ? 32'sh80000000 : 32'sh7fffffff);
    end else if (qneg_q) begin
      dres = (dq_q > DIV_STEPS'(33'h080000000)) ? 32'sh80000000 : 32'(-dq_q);
    end else begin
      dres = (dq_q > DIV_STEPS'(33'h07fffffff)) ? 32'sh7fffffff : dq_q[31:0];
    end
  end

  logic signed [31:0] acc_sat;
  assign acc_sat = sat32(acc_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
      zero_q <= 1'b0;
      oor_q  <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_START: begin
          zero_q <= 1'b0;
          oor_q  <= 1'b0;
        end
        OP_OOR:      oor_q  <= 1'b1;
        OP_DIV_INIT: dcnt_q <= DCNT_W'(DIV_STEPS);
        OP_DIV_STEP: dcnt_q <= dcnt_q - 1'b1;
        OP_DIV_TSET, OP_DIV_TADD: begin
          if (!dnz_q) zero_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: q_q <= query_param_i;
      OP_START: begin
        if (cmd_i.dsel) begin
          seg_q <= '0;
        end else begin
          seg_q <= q_q[FRAC_BITS +: SEG_W];
        end
        t_q <= 32'({1'b0, q_q[FRAC_BITS-1:0]});
      end
      OP_OOR: begin
        x_q <= '0;
        y_q <= '0;
      end
      OP_KCMP: begin
        k1_q <= kdata_i;
        if (stat_o.kgt && !stat_o.seg_last) seg_q <= seg_q + 1'b1;
      end
      OP_K0LD: k0_q <= kdata_i;
      OP_DIV_INIT: begin
        rem_q   <= '0;
        dq_q    <= {nmag, {FRAC_BITS{1'b0}}};
        dmag_q  <= dmag;
        nsgn_q  <= num[63];
        nzero_q <= (num == 64'sd0);
        dnz_q   <= (den != 64'sd0);
        qneg_q  <= num[63] ^ den[63];
      end
      OP_DIV_STEP: begin
        rem_q <= rem_ge ? 33'(rem_sh - {1'b0, dmag_q}) : rem_sh[32:0];
        dq_q  <= {dq_q[DIV_STEPS-2:0], rem_ge};
      end
      OP_DIV_TSET: t_q <= dres;
      OP_DIV_TADD: t_q <= sat32(64'(t_q) + 64'(dres));
      OP_WLOAD:    w_q[cmd_i.idx] <= cdata_i;
      OP_MUL_TT, OP_MUL_T2T, OP_MULB: prod_q <= mul_p;
      OP_WB_T2: begin
        t2_q  <= sat32(prod_sh);
        acc_q <= '0;
      end
      OP_WB_T3:    t3_q    <= sat32(prod_sh);
      OP_ACC:      acc_q   <= acc_q + prod_sh;
      OP_WB_RESID: resid_q <= sat32(64'(q_q) - 64'(acc_sat));
      OP_WB_SLOPE: slope_q <= acc_sat;
      OP_WB_X:     x_q     <= acc_sat;
      OP_WB_Y:     y_q     <= acc_sat;
      default: ;
    endcase
  end

  // the START op uses dsel low in plain mode; the top level drives dsel from knot_mode for it
  assign kaddr_o = cmd_i.khi ? KNOT_AW'(seg_q + 1'b1) : KNOT_AW'(seg_q);
  assign caddr_o = {seg_q[COEFF_AW-4:0], cmd_i.cdim, cmd_i.cidx};

  assign stat_o.plain_oor = q_q[31] ||
                            (q_q[31:FRAC_BITS] >= (32 - FRAC_BITS)'(nseg_i));
  assign stat_o.kgt       = kdata_i < q_q;
  assign stat_o.seg_last  = (seg_q + 1'b1) == nseg_i;
  assign stat_o.div_done  = (dcnt_q == '0);

  assign point_x_o = x_q;
  assign point_y_o = y_q;
  assign status_o  = oor_q ? STAT_RANGE : (zero_q ? STAT_ZDIV : STAT_OK);

endmodule

### hw/rtl/hermite_spline_point_eval.sv
// ----------------------------------------------------------------------------
// hermite_spline_point_eval
// 2-D cubic Hermite spline point evaluator, signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (in_valid_i / in_stall_o): action 0 writes a coefficient
//    word (segment*8 + dim*4 + k), action 1 writes a knot, action 2 evaluates
//    at query_param_i, action 3 is dropped. Loads complete in the accept
//    cycle; an evaluate holds the request channel until its result has been
//    moved into the output register.
//  - Result channel (out_valid_o / out_stall_i): one result per evaluate,
//    held stable while stalled. A result waiting there does not block new
//    loads; the next evaluate finishes its work and then waits for the slot.
//  - Work per evaluate: plain mode needs no division. Knot mode searches
//    the knots, then runs six divisions, each through a 49-step radix-2
//    divider, and every product goes through the one shared 32x32
//    multiplier.
//  - Config via APB: reg 0 num_segments (addr 0), reg 1 knot_mode (addr 4);
//    write only while idle.
//  - Reset: num_segments = 1, knot_mode = 0, no result pending. Coefficient
//    and knot RAMs are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module hermite_spline_point_eval (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [10:0]        address_i,
  input  logic signed [31:0] load_value_i,
  input  logic signed [31:0] query_param_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic [1:0]         status_o,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hsp_pkg::*;

  // config registers
  logic [8:0] num_seg_q;
  logic       knot_mode_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_seg_q   <= 9'd1;
      knot_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NSEG: num_seg_q   <= pwdata[8:0];
        REG_MODE: knot_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NSEG: prdata = 32'(num_seg_q);
      REG_MODE: prdata = 32'(knot_mode_q);
      default:  prdata = '0;
    endcase
  end

  // effective segment count, capped at the store size
  logic [SEG_W-1:0] nseg_eff;
  assign nseg_eff = (32'(num_seg_q) > MAX_SEGMENTS) ? SEG_W'(MAX_SEGMENTS)
                                                   : SEG_W'(num_seg_q);

  // request accept and store writes
  logic    in_acc;
  action_e act;
  assign act    = action_e'(action_i);
  assign in_acc = in_valid_i && !in_stall_o;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [KNOT_AW-1:0]  kaddr;
  logic [COEFF_AW-1:0] caddr;
  logic [31:0]         kdata, cdata;
  logic                cwe, kwe;

  assign cwe = in_acc && act == ACT_COEFF && 32'(address_i) < COEFF_DEPTH;
  assign kwe = in_acc && act == ACT_KNOT  && 32'(address_i) < KNOT_DEPTH;

  hsp_ram #(
    .WIDTH (32),
    .DEPTH (COEFF_DEPTH)
  ) u_coeff_ram (
    .clk_i   (clk_i),
    .we_i    (cwe),
    .waddr_i (address_i[COEFF_AW-1:0]),
    .wdata_i (load_value_i),
    .re_i    (cmd.crd),
    .raddr_i (caddr),
    .rdata_o (cdata)
  );

  hsp_ram #(
    .WIDTH (32),
    .DEPTH (KNOT_DEPTH)
  ) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (kwe),
    .waddr_i (address_i[KNOT_AW-1:0]),
    .wdata_i (load_value_i),
    .re_i    (cmd.krd),
    .raddr_i (kaddr),
    .rdata_o (kdata)
  );

  // output register: free when empty or being taken this cycle
  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;

  hsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (act),
    .knot_mode_i (knot_mode_q),
    .nseg_zero_i (nseg_eff == '0),
    .out_free_i  (out_free),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  // dsel doubles as the knot-mode flag for the start op
  dp_cmd_t dp_cmd;
  always_comb begin
    dp_cmd = cmd;
    if (cmd.op == OP_START) dp_cmd.dsel = knot_mode_q;
  end

  logic signed [31:0] dp_x, dp_y;
  status_e            dp_status;

  hsp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .query_param_i (query_param_i),
    .nseg_i        (nseg_eff),
    .kdata_i       (kdata),
    .cdata_i       (cdata),
    .kaddr_o       (kaddr),
    .caddr_o       (caddr),
    .stat_o        (stat),
    .point_x_o     (dp_x),
    .point_y_o     (dp_y),
    .status_o      (dp_status)
  );

  // result register
  logic               out_valid_q;
  logic signed [31:0] px_q, py_q;
  logic [1:0]         pst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      px_q  <= dp_x;
      py_q  <= dp_y;
      pst_q <= dp_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign status_o    = pst_q;

endmodule

### hw/rtl/hsp_checker.sv
// ----------------------------------------------------------------------------
// hsp_checker
// Port-level checks for the spline evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module hsp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         action_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] point_x_o,
  input logic signed [31:0] point_y_o,
  input logic [1:0]         status_o
);
  import hsp_pkg::*;

  // a held result does not move
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(point_x_o) &&
    $stable(point_y_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_RANGE |-> point_x_o == 0 && point_y_o == 0)
    else $error("out-of-range result not zero");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i == ACT_EVAL |=> in_stall_o)
    else $error("evaluate request did not hold the channel");

endmodule

bind hermite_spline_point_eval hsp_checker u_hsp_checker (.*);
